// ===== rtl/nbg_pkg.sv =====
`default_nettype none
package nbg_pkg;

  localparam int MAX_BODIES_DEF = 16;
  localparam int COORD_W = 32;
  localparam int FRAC_BITS = 16;
  localparam int AXES = 3;
  localparam int MASS_W = 32;
  localparam int BODY_W = MASS_W + AXES * COORD_W;
  localparam int VEL_W = AXES * COORD_W;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef enum logic [1:0] {
    REG_GRAV  = 2'd0,
    REG_DT    = 2'd1,
    REG_COUNT = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } op_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_RDI,
    S_LDI,
    S_RDJ,
    S_DIF,
    S_SQ,
    S_SQCHK,
    S_SQRT,
    S_DEN0,
    S_DEN1,
    S_GM,
    S_NUM0,
    S_NUM1,
    S_DGO,
    S_DIV,
    S_VEL,
    S_POS,
    S_WR
  } state_t;

  function automatic coord_t sat_coord(input logic signed [63:0] v);
    logic signed [63:0] cmax;
    logic signed [63:0] cmin;
    cmax = 64'sd2147483647;
    cmin = -64'sd2147483648;
    if (v > cmax) begin
      sat_coord = 32'sh7FFF_FFFF;
    end else if (v < cmin) begin
      sat_coord = 32'sh8000_0000;
    end else begin
      sat_coord = v[COORD_W-1:0];
    end
  endfunction

  function automatic logic [COORD_W-1:0] mag(input coord_t x);
    mag = x[COORD_W-1] ? COORD_W'(-x) : COORD_W'(x);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/nbg_store.sv =====
`default_nettype none
module nbg_store #(
  parameter int MAX_BODIES = nbg_pkg::MAX_BODIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [$clog2(MAX_BODIES)-1:0] wr_addr,
  input  logic [nbg_pkg::BODY_W-1:0]    wr_body,
  input  logic [nbg_pkg::VEL_W-1:0]     wr_vel,
  input  logic [$clog2(MAX_BODIES)-1:0] rd_addr,
  output logic [nbg_pkg::BODY_W-1:0]    rd_body,
  output logic [nbg_pkg::VEL_W-1:0]     rd_vel
);
  import nbg_pkg::*;

  logic [BODY_W-1:0]     body_mem [MAX_BODIES];
  logic [VEL_W-1:0]      vel_mem  [MAX_BODIES];
  logic [MAX_BODIES-1:0] valid;
  logic [BODY_W-1:0]     rd_body_q;
  logic [VEL_W-1:0]      rd_vel_q;
  logic                  rd_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      body_mem[wr_addr] <= wr_body;
      vel_mem[wr_addr]  <= wr_vel;
    end
    rd_body_q <= body_mem[rd_addr];
    rd_vel_q  <= vel_mem[rd_addr];
  end

  // never-written slots read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      rd_valid <= valid[rd_addr];
    end
  end

  assign rd_body = rd_valid ? rd_body_q : '0;
  assign rd_vel  = rd_valid ? rd_vel_q : '0;

endmodule
`default_nettype wire

// ===== rtl/nbg_sqrt.sv =====
`default_nettype none
module nbg_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        done,
  output logic [31:0] root
);
  import nbg_pkg::*;

  logic [63:0] x;
  logic [63:0] res;
  logic [63:0] bitv;
  logic        run;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        x    <= radicand;
        res  <= '0;
        bitv <= 64'h4000_0000_0000_0000;
        run  <= 1'b1;
      end else if (run) begin
        if (x >= res + bitv) begin
          x   <= x - (res + bitv);
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
        if (bitv == 64'd1) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign root = res[31:0];

endmodule
`default_nettype wire

// ===== rtl/nbg_div.sv =====
`default_nettype none
module nbg_div (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [127:0] num,
  input  logic [95:0]  den,
  output logic         done,
  output logic [31:0]  quo_mag
);
  import nbg_pkg::*;

  // quotient clamped to 2^31; anything at or above 2^33 is flagged up front
  logic [127:0] r;
  logic [129:0] dsh;
  logic [32:0]  q;
  logic         ovf;
  logic [5:0]   cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        r   <= num;
        dsh <= 130'(den) << 33;
        q   <= '0;
        ovf <= 1'b0;
        cnt <= 6'd34;
      end else if (cnt != 6'd0) begin
        if (cnt == 6'd34) begin
          ovf <= {2'b00, r} >= dsh;
        end else if ({2'b00, r} >= dsh) begin
          r <= r - dsh[127:0];
          q <= {q[31:0], 1'b1};
        end else begin
          q <= {q[31:0], 1'b0};
        end
        dsh <= dsh >> 1;
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          done <= 1'b1;
        end
      end
    end
  end

  assign quo_mag = (ovf || q > 33'h0_8000_0000) ? 32'h8000_0000 : q[31:0];

endmodule
`default_nettype wire

// ===== rtl/nbody_gravity_euler_step.sv =====
`default_nettype none
// Direct-sum gravity integrator, semi-implicit Euler, signed Q16.16.
// Request channel: start/busy. A request is taken when start is high and
// busy is low. op = load writes one body (mass, position, velocity) into
// slot body_index and returns nothing; busy stays low. op = step updates
// bodies 0..body_count-1, with the count clamped to MAX_BODIES, in index
// order, in place, and emits one result per body: out_valid is high for
// exactly one cycle with out_index, new position/velocity and last_body
// on the final one. The receiver cannot stall; every result must be
// captured when shown. Each interacting (non-coincident) pair waits for
// the square root and three divides, one per axis, and uses a single
// shared 32x32 multiplier; each body also spends states on memory access,
// skipping itself and the velocity/position update. Coincident pairs
// skip the square root and divides. busy is high for the step.
// Config: APB at byte offsets 0 (G), 4 (dt), 8 (body count); pready is
// always high. Write config only while busy is low.
// Reset (rst, synchronous) returns G = 1.0, dt = 655/65536, body count 0
// and makes every slot read as zero until loaded.
module nbody_gravity_euler_step #(
  parameter int MAX_BODIES = nbg_pkg::MAX_BODIES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [3:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  input  logic                 start,
  output logic                 busy,
  input  logic                 op,
  input  logic [3:0]           body_index,
  input  logic [31:0]          body_mass,
  input  logic signed [31:0]   load_px,
  input  logic signed [31:0]   load_py,
  input  logic signed [31:0]   load_pz,
  input  logic signed [31:0]   load_vx,
  input  logic signed [31:0]   load_vy,
  input  logic signed [31:0]   load_vz,
  output logic                 out_valid,
  output logic [3:0]           out_index,
  output logic signed [31:0]   new_px,
  output logic signed [31:0]   new_py,
  output logic signed [31:0]   new_pz,
  output logic signed [31:0]   new_vx,
  output logic signed [31:0]   new_vy,
  output logic signed [31:0]   new_vz,
  output logic                 last_body
);
  import nbg_pkg::*;

  localparam int AW = $clog2(MAX_BODIES);
  localparam int CW = $clog2(MAX_BODIES + 1);

  state_t state, state_next;

  logic [31:0]   g, dt;
  logic [4:0]    body_count;
  logic          cfg_wr;

  logic [CW-1:0] i, j, n, n_clamp;
  logic [1:0]    k;
  coord_t        pi  [AXES];
  coord_t        vi  [AXES];
  coord_t        dd  [AXES];
  coord_t        acc [AXES];
  logic [31:0]   mi, mj, sroot;
  logic [63:0]   s2, gm;
  logic [95:0]   den, num;

  logic [31:0]   mul_a, mul_b;
  logic [63:0]   mul_p;

  logic          load_go, step_go;
  logic          sq_start, sq_done, div_start, div_done;
  logic [31:0]   sq_root, div_mag;

  logic              wr_en;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [BODY_W-1:0] wr_body, rd_body;
  logic [VEL_W-1:0]  wr_vel, rd_vel;

  logic signed [63:0] a_full, acc_sum, sc, sv;

  // configuration
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      g          <= 32'd65536;
      dt         <= 32'd655;
      body_count <= 5'd0;
    end else if (cfg_wr) begin
      case (cfg_reg_t'(paddr[3:2]))
        REG_GRAV:  g          <= pwdata;
        REG_DT:    dt         <= pwdata;
        REG_COUNT: body_count <= pwdata[4:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    case (cfg_reg_t'(paddr[3:2]))
      REG_GRAV:  prdata = g;
      REG_DT:    prdata = dt;
      REG_COUNT: prdata = 32'(body_count);
      default:   prdata = '0;
    endcase
  end

  assign busy    = state != S_IDLE;
  assign load_go = start && !busy && op_t'(op) == OP_LOAD && int'(body_index) < MAX_BODIES;
  assign step_go = start && !busy && op_t'(op) == OP_STEP;
  assign n_clamp = (int'(body_count) > MAX_BODIES) ? CW'(MAX_BODIES) : CW'(body_count);

  // body store
  always_comb begin
    if (state == S_WR) begin
      wr_en   = 1'b1;
      wr_addr = i[AW-1:0];
      wr_body = {mi, pi[2], pi[1], pi[0]};
      wr_vel  = {vi[2], vi[1], vi[0]};
    end else begin
      wr_en   = load_go;
      wr_addr = AW'(body_index);
      wr_body = {body_mass, load_pz, load_py, load_px};
      wr_vel  = {load_vz, load_vy, load_vx};
    end
    rd_addr = (state == S_RDJ) ? j[AW-1:0] : i[AW-1:0];
  end

  nbg_store #(.MAX_BODIES(MAX_BODIES)) u_store (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_body (wr_body),
    .wr_vel  (wr_vel),
    .rd_addr (rd_addr),
    .rd_body (rd_body),
    .rd_vel  (rd_vel)
  );

  nbg_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (s2),
    .done     (sq_done),
    .root     (sq_root)
  );

  nbg_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .num     (128'(num) << FRAC_BITS),
    .den     (den),
    .done    (div_done),
    .quo_mag (div_mag)
  );

  // shared multiplier
  always_comb begin
    case (state)
      S_SQ:    begin mul_a = mag(dd[k]);  mul_b = mag(dd[k]); end
      S_DEN0:  begin mul_a = s2[31:0];    mul_b = sroot;      end
      S_DEN1:  begin mul_a = s2[63:32];   mul_b = sroot;      end
      S_GM:    begin mul_a = g;           mul_b = mj;         end
      S_NUM0:  begin mul_a = gm[31:0];    mul_b = mag(dd[k]); end
      S_NUM1:  begin mul_a = gm[63:32];   mul_b = mag(dd[k]); end
      S_VEL:   begin mul_a = mag(acc[k]); mul_b = dt;         end
      S_POS:   begin mul_a = mag(vi[k]);  mul_b = dt;         end
      default: begin mul_a = '0;          mul_b = '0;         end
    endcase
  end
  assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

  always_comb begin
    a_full  = dd[k][COORD_W-1] ? -$signed({32'd0, div_mag}) : $signed({32'd0, div_mag});
    acc_sum = 64'(acc[k]) + 64'(sat_coord(a_full));
    sc      = $signed(mul_p >> FRAC_BITS);
    sv      = (state == S_VEL ? acc[k][COORD_W-1] : vi[k][COORD_W-1]) ? -sc : sc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    sq_start   = 1'b0;
    div_start  = 1'b0;
    case (state)
      S_IDLE: begin
        if (step_go && n_clamp != '0) begin
          state_next = S_RDI;
        end
      end
      S_RDI: state_next = S_LDI;
      S_LDI: state_next = S_RDJ;
      S_RDJ: begin
        if (j == n) begin
          state_next = S_VEL;
        end else if (j != i) begin
          state_next = S_DIF;
        end
      end
      S_DIF: state_next = S_SQ;
      S_SQ: begin
        if (k == 2'd2) begin
          state_next = S_SQCHK;
        end
      end
      S_SQCHK: begin
        if (s2 == '0) begin
          state_next = S_RDJ;
        end else begin
          sq_start   = 1'b1;
          state_next = S_SQRT;
        end
      end
      S_SQRT: begin
        if (sq_done) begin
          state_next = S_DEN0;
        end
      end
      S_DEN0: state_next = S_DEN1;
      S_DEN1: state_next = S_GM;
      S_GM:   state_next = S_NUM0;
      S_NUM0: state_next = S_NUM1;
      S_NUM1: state_next = S_DGO;
      S_DGO: begin
        div_start  = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          state_next = (k == 2'd2) ? S_RDJ : S_NUM0;
        end
      end
      S_VEL: state_next = S_POS;
      S_POS: begin
        if (k == 2'd2) begin
          state_next = S_WR;
        end else begin
          state_next = S_VEL;
        end
      end
      S_WR: begin
        state_next = ((i + CW'(1)) == n) ? S_IDLE : S_RDI;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        n <= n_clamp;
        i <= '0;
      end
      S_LDI: begin
        for (int a = 0; a < AXES; a++) begin
          pi[a]  <= rd_body[a*COORD_W +: COORD_W];
          vi[a]  <= rd_vel[a*COORD_W +: COORD_W];
          acc[a] <= '0;
        end
        mi <= rd_body[AXES*COORD_W +: MASS_W];
        j  <= '0;
      end
      S_RDJ: begin
        k <= 2'd0;
        if (j != n && j == i) begin
          j <= j + CW'(1);
        end
      end
      S_DIF: begin
        for (int a = 0; a < AXES; a++) begin
          dd[a] <= sat_coord(64'(coord_t'(rd_body[a*COORD_W +: COORD_W])) - 64'(pi[a]));
        end
        mj <= rd_body[AXES*COORD_W +: MASS_W];
        s2 <= '0;
      end
      S_SQ: begin
        s2 <= s2 + mul_p;
        k  <= (k == 2'd2) ? 2'd0 : k + 2'd1;
      end
      S_SQCHK: begin
        if (s2 == '0) begin
          j <= j + CW'(1);
        end
      end
      S_SQRT: begin
        if (sq_done) begin
          sroot <= sq_root;
        end
      end
      S_DEN0: den <= 96'(mul_p);
      S_DEN1: den <= den + {mul_p, 32'd0};
      S_GM:   gm  <= mul_p;
      S_NUM0: num <= 96'(mul_p);
      S_NUM1: num <= num + {mul_p, 32'd0};
      S_DIV: begin
        if (div_done) begin
          acc[k] <= sat_coord(acc_sum);
          if (k == 2'd2) begin
            k <= 2'd0;
            j <= j + CW'(1);
          end else begin
            k <= k + 2'd1;
          end
        end
      end
      S_VEL: vi[k] <= sat_coord(64'(vi[k]) + sv);
      S_POS: begin
        pi[k] <= sat_coord(64'(pi[k]) + sv);
        k     <= (k == 2'd2) ? 2'd0 : k + 2'd1;
      end
      S_WR: begin
        i         <= i + CW'(1);
        out_index <= 4'(i);
        new_px    <= pi[0];
        new_py    <= pi[1];
        new_pz    <= pi[2];
        new_vx    <= vi[0];
        new_vy    <= vi[1];
        new_vz    <= vi[2];
        last_body <= (i + CW'(1)) == n;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= state == S_WR;
    end
  end

`ifndef SYNTHESIS
  a_result_from_wb: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $past(state) == S_WR)
    else $error("result strobe without write-back");
  a_sqrt_when_waiting: assert property (@(posedge clk) disable iff (rst)
    sq_done |-> state == S_SQRT)
    else $error("sqrt finished outside its wait state");
  a_div_when_waiting: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divide finished outside its wait state");
  a_last_ends_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_body |-> state == S_IDLE)
    else $error("step still running after last body");
`endif

endmodule
`default_nettype wire

// ===== tb/nbody_gravity_euler_step_test.sv =====
`timescale 1ns / 100ps
module nbody_gravity_euler_step_test;
  import nbg_pkg::*;

  localparam int WATCHDOG_LIMIT = 40000;
  localparam int SETTLE_CYCLES = 20;
  localparam logic [3:0] ADDR_UNUSED = 4'd12;
  localparam int NBODY = 16;

  typedef struct {
    op_t op;
    logic [3:0] idx;
    logic [31:0] mass;
    logic [31:0] p[3];
    logic [31:0] v[3];
  } body_req_t;

  typedef struct {
    logic [3:0] idx;
    logic [31:0] p[3];
    logic [31:0] v[3];
    logic last;
  } body_update_t;

  class euler_scoreboard;
    longint pos[NBODY][3];
    longint vel[NBODY][3];
    logic [31:0] mass[NBODY];
    logic [31:0] grav;
    logic [31:0] dt;
    logic [4:0] count;
    body_update_t pending_updates[$];
    int errors;
    int updates_seen;
    int steps;
    int loads;

    function new();
      foreach (pos[i, k]) begin
        pos[i][k] = 0;
        vel[i][k] = 0;
      end
      foreach (mass[i]) mass[i] = '0;
      grav = 32'd65536;
      dt = 32'd655;
      count = '0;
      errors = 0;
      updates_seen = 0;
      steps = 0;
      loads = 0;
    endfunction

    function void write_reg(logic [3:0] addr, logic [31:0] data);
      case (addr)
        4 * REG_GRAV: grav = data;
        4 * REG_DT: dt = data;
        4 * REG_COUNT: count = data[4:0];
        default: ;
      endcase
    endfunction

    function longint clamp(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
    endfunction

    function logic [63:0] root(logic [63:0] x);
      logic [63:0] res;
      logic [63:0] b;
      res = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
        if (x >= res + b) begin
          x = x - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    function longint times_dt(longint x);
      logic [63:0] m;
      logic [63:0] p;
      m = x < 0 ? -x : x;
      p = (m * {32'd0, dt}) >> FRAC_BITS;
      return x < 0 ? -longint'(p) : longint'(p);
    endfunction

    function void advance_body(int i, int n);
      longint acc[3];
      longint d[3];
      longint a;
      logic [63:0] s2;
      logic [63:0] s;
      logic [63:0] gm;
      logic [63:0] md;
      logic [127:0] q;
      logic [127:0] lim;
      acc = '{0, 0, 0};
      lim = 128'd1 << 31;
      for (int j = 0; j < n; j++) begin
        if (j == i) continue;
        s2 = 0;
        for (int k = 0; k < 3; k++) begin
          d[k] = clamp(pos[j][k] - pos[i][k]);
          s2 = s2 + 64'(d[k] * d[k]);
        end
        if (s2 == 0) continue;
        s = root(s2);
        gm = {32'd0, grav} * {32'd0, mass[j]};
        for (int k = 0; k < 3; k++) begin
          md = d[k] < 0 ? -d[k] : d[k];
          q = (({64'd0, gm} * {64'd0, md}) << FRAC_BITS) / ({64'd0, s2} * {64'd0, s});
          if (q > lim) q = lim;
          a = d[k] < 0 ? -longint'(q[63:0]) : longint'(q[63:0]);
          acc[k] = clamp(acc[k] + clamp(a));
        end
      end
      for (int k = 0; k < 3; k++) begin
        vel[i][k] = clamp(vel[i][k] + times_dt(acc[k]));
        pos[i][k] = clamp(pos[i][k] + times_dt(vel[i][k]));
      end
    endfunction

    function void note_request(body_req_t r);
      body_update_t u;
      int n;
      if (r.op == OP_LOAD) begin
        loads++;
        mass[r.idx] = r.mass;
        for (int k = 0; k < 3; k++) begin
          pos[r.idx][k] = longint'(signed'(r.p[k]));
          vel[r.idx][k] = longint'(signed'(r.v[k]));
        end
        return;
      end
      steps++;
      n = count > NBODY ? NBODY : count;
      for (int i = 0; i < n; i++) begin
        advance_body(i, n);
        u.idx = i[3:0];
        for (int k = 0; k < 3; k++) begin
          u.p[k] = pos[i][k][31:0];
          u.v[k] = vel[i][k][31:0];
        end
        u.last = (i + 1 == n);
        pending_updates.insert(pending_updates.size(), u);
      end
    endfunction

    function void field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s: expected %h, got %h", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_update(body_update_t got);
      body_update_t e;
      if (pending_updates.size() == 0) begin
        $error("unexpected body update for index %0d", got.idx);
        errors++;
        return;
      end
      e = pending_updates.pop_front();
      updates_seen++;
      field("out_index", e.idx, got.idx);
      field("new_px", e.p[0], got.p[0]);
      field("new_py", e.p[1], got.p[1]);
      field("new_pz", e.p[2], got.p[2]);
      field("new_vx", e.v[0], got.v[0]);
      field("new_vy", e.v[1], got.v[1]);
      field("new_vz", e.v[2], got.v[2]);
      field("last_body", e.last, got.last);
    endfunction
  endclass

  logic clk, rst;
  logic psel, penable, pwrite;
  logic [3:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  logic start, busy;
  logic op;
  logic [3:0] body_index;
  logic [31:0] body_mass;
  logic signed [31:0] load_px, load_py, load_pz, load_vx, load_vy, load_vz;
  logic out_valid;
  logic [3:0] out_index;
  logic signed [31:0] new_px, new_py, new_pz, new_vx, new_vy, new_vz;
  logic last_body;

  euler_scoreboard sb;
  int idle_pct;
  int sent;
  int quiet_cycles;

  nbody_gravity_euler_step dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .start(start), .busy(busy), .op(op), .body_index(body_index),
    .body_mass(body_mass),
    .load_px(load_px), .load_py(load_py), .load_pz(load_pz),
    .load_vx(load_vx), .load_vy(load_vy), .load_vz(load_vz),
    .out_valid(out_valid), .out_index(out_index),
    .new_px(new_px), .new_py(new_py), .new_pz(new_pz),
    .new_vx(new_vx), .new_vy(new_vy), .new_vz(new_vz),
    .last_body(last_body)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    body_update_t got;
    if (!rst && out_valid) begin
      got.idx = out_index;
      got.p = '{new_px, new_py, new_pz};
      got.v = '{new_vx, new_vy, new_vz};
      got.last = last_body;
      sb.check_update(got);
    end
  end

  always @(posedge clk) begin
    if (rst || out_valid || (start && !busy)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired");
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // called at a rising edge; returns at the edge where the request is taken
  task automatic send(body_req_t r);
    int gap;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    op <= r.op;
    body_index <= r.idx;
    body_mass <= r.mass;
    load_px <= r.p[0];
    load_py <= r.p[1];
    load_pz <= r.p[2];
    load_vx <= r.v[0];
    load_vy <= r.v[1];
    load_vz <= r.v[2];
    do @(posedge clk); while (busy);
    sb.note_request(r);
    sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (busy || sb.pending_updates.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(logic [3:0] addr, logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    sb.write_reg(addr, data);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic setup(logic [31:0] g, logic [31:0] d, logic [4:0] n);
    drain();
    reg_write(4 * REG_GRAV, g);
    reg_write(4 * REG_DT, d);
    reg_write(4 * REG_COUNT, {27'd0, n});
  endtask

  function automatic logic [31:0] coord(int mode);
    case (mode)
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 32'h00C8_0000)) - 32'sh0064_0000);
      2: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000);
    endcase
  endfunction

  function automatic body_req_t load_req(logic [3:0] idx, int mode);
    body_req_t r;
    r.op = OP_LOAD;
    r.idx = idx;
    r.mass = $urandom_range(3) == 0 ? $urandom : $urandom_range(32'h0010_0000);
    for (int k = 0; k < 3; k++) begin
      r.p[k] = coord(mode);
      r.v[k] = coord($urandom_range(3) == 0 ? 0 : 3);
    end
    return r;
  endfunction

  function automatic body_req_t step_req();
    body_req_t r;
    r = load_req(4'($urandom), 0);
    r.op = OP_STEP;
    return r;
  endfunction

  initial begin
    body_req_t r;
    int n;
    int mode;
    sb = new();
    sent = 0;
    idle_pct = 0;
    quiet_cycles = 0;
    rst = 1'b1;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    start = 0; op = 0; body_index = '0; body_mass = '0;
    load_px = '0; load_py = '0; load_pz = '0;
    load_vx = '0; load_vy = '0; load_vz = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero bodies, then a lone body drifting at reset constants
    send(step_req());
    r = load_req(4'd0, 1);
    send(r);
    setup(32'd65536, 32'd655, 5'd1);
    send(step_req());
    // extreme fields on slots 0 and 15, far apart
    r = load_req(4'd0, 2);
    r.mass = 32'hFFFF_FFFF;
    r.p = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
    r.v = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0};
    send(r);
    r.idx = 4'd15;
    r.mass = 32'd0;
    r.p = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
    r.v = '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF};
    send(r);
    setup(32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd16);
    send(step_req());
    // coincident pair plus a close neighbor
    send(load_req(4'd1, 3));
    r = load_req(4'd2, 3);
    r.p = '{32'h0001_0000, 32'h0, 32'h0};
    send(r);
    r.idx = 4'd3;
    send(r);
    setup(32'hFFFF_FFFF, 32'd0, 5'd4);
    send(step_req());
    drain();
    reg_write(ADDR_UNUSED, 32'hFFFF_FFFF);
    setup(32'd0, 32'd65536, 5'd31);
    send(step_req());
    setup(32'd65536, 32'd655, 5'd3);
    send(step_req());
    send(step_req());

    while (sent < 150) begin
      case ((sent / 30) % 3)
        0: idle_pct = 0;
        1: idle_pct = 82;
        default: idle_pct = 34;
      endcase
      case ($urandom_range(19))
        0: n = 16;
        1: n = $urandom_range(17, 31);
        2: n = $urandom_range(0, 1);
        default: n = $urandom_range(2, 6);
      endcase
      if (n >= 16 && $urandom_range(2) != 0) n = $urandom_range(2, 6);
      setup($urandom_range(3) == 0 ? $urandom : $urandom_range(32'h0004_0000),
            $urandom_range(3) == 0 ? $urandom : $urandom_range(32'h0000_1000),
            5'(n));
      mode = $urandom_range(3);
      for (int i = 0; i < (n > 16 ? 16 : n); i++) begin
        r = load_req(4'(i), $urandom_range(7) == 0 ? $urandom_range(3) : mode);
        if (i > 0 && $urandom_range(9) == 0) r.p = '{load_px, load_py, load_pz};
        send(r);
      end
      if ($urandom_range(4) == 0) send(load_req(4'($urandom), $urandom_range(3)));
      repeat ($urandom_range(1, 3)) send(step_req());
    end

    drain();
    $display("%0d loads and %0d steps sent, %0d body updates checked",
             sb.loads, sb.steps, sb.updates_seen);
    $display("register extremes, coincident and far pairs, clamped counts covered");
    if (sb.errors == 0 && sb.pending_updates.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
